>>> rtl/core/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare helpers of the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int CFG_W     = 12;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    // input row runs up to height + 1 while the frame drains
    localparam int ROW_W     = CFG_W + 1;
    localparam int CNT_W     = (COL_W > CFG_W) ? COL_W : CFG_W;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = CH_W * NUM_CH;
    localparam int WIN_N     = 9;
    localparam int CENTER    = 4;
    localparam int IDX_W     = 2;

    typedef logic [IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_WIDTH  = 2'd0;
    localparam t_reg_idx REG_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        t_pix             px;
        logic             emit;
        logic             interior;
        logic             line_end;
        logic             frame_end;
    } t_front;

    typedef struct packed {
        logic valid;
        logic interior;
        logic line_end;
        logic frame_end;
    } t_side;

    typedef struct packed {
        t_pix pix;
        logic line_end;
        logic frame_end;
    } t_out;

    typedef struct packed {
        t_chan hi;
        t_chan mid;
        t_chan lo;
    } t_trip;

    function automatic t_chan chan(input t_pix p, input int ch);
        return p[ch*CH_W +: CH_W];
    endfunction

    function automatic t_chan min2(input t_chan a, input t_chan b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_chan max2(input t_chan a, input t_chan b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_chan min3(input t_chan a, input t_chan b, input t_chan c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_chan max3(input t_chan a, input t_chan b, input t_chan c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_chan med3(input t_chan a, input t_chan b, input t_chan c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_trip sort3(input t_chan a, input t_chan b, input t_chan c);
        t_trip t;
        t.lo  = min3(a, b, c);
        t.mid = med3(a, b, c);
        t.hi  = max3(a, b, c);
        return t;
    endfunction

endpackage

>>> rtl/core/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old entry when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mf3_window.sv
// ----------------------------------------------------------------------------
// mf3_window
// Line store access and 3x3 window shift register.
// ----------------------------------------------------------------------------
module mf3_window (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mf3_pkg::t_front i_front,
    output mf3_pkg::t_win   o_win,
    output mf3_pkg::t_side  o_side
);

    mf3_pkg::t_front r_s1;
    logic            r_fwd;
    mf3_pkg::t_pix   r_fwd_up;
    mf3_pkg::t_pix   r_fwd_lo;
    mf3_pkg::t_win   r_win;
    mf3_pkg::t_side  r_side;

    logic [2*mf3_pkg::PIX_W-1:0] w_rdata;
    mf3_pkg::t_pix               w_up;
    mf3_pkg::t_pix               w_lo;

    // each entry holds {line two above, line just above}
    mf3_ram #(
        .WIDTH (2 * mf3_pkg::PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_en & r_s1.valid),
        .i_waddr (r_s1.col),
        .i_wdata ({w_lo, r_s1.px}),
        .i_re    (i_en),
        .i_raddr (i_front.col),
        .o_rdata (w_rdata)
    );

    // same column on consecutive words: take the values the older word wrote
    assign w_up = r_fwd ? r_fwd_up : w_rdata[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
    assign w_lo = r_fwd ? r_fwd_lo : w_rdata[mf3_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid   <= 1'b0;
            r_fwd        <= 1'b0;
            r_win        <= '0;
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_s1     <= i_front;
            r_fwd    <= i_front.valid & r_s1.valid & (i_front.col == r_s1.col);
            r_fwd_up <= w_lo;
            r_fwd_lo <= r_s1.px;
            if (r_s1.valid) begin
                for (int row = 0; row < 3; row++) begin
                    r_win[3*row]     <= r_win[3*row + 1];
                    r_win[3*row + 1] <= r_win[3*row + 2];
                end
                r_win[2] <= w_up;
                r_win[5] <= w_lo;
                r_win[8] <= r_s1.px;
            end
            r_side.valid     <= r_s1.valid & r_s1.emit;
            r_side.interior  <= r_s1.interior;
            r_side.line_end  <= r_s1.line_end;
            r_side.frame_end <= r_s1.frame_end;
        end
    end

    assign o_win  = r_win;
    assign o_side = r_side;

endmodule

>>> rtl/core/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median network: row sort, column select, final median of three.
// ----------------------------------------------------------------------------
module mf3_median (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  mf3_pkg::t_win  i_win,
    input  mf3_pkg::t_side i_side,
    output logic           o_valid,
    output mf3_pkg::t_out  o_data
);

    mf3_pkg::t_trip r_rows [mf3_pkg::NUM_CH][3];
    mf3_pkg::t_side r_side1;
    mf3_pkg::t_pix  r_ctr1;

    mf3_pkg::t_chan r_lo_max  [mf3_pkg::NUM_CH];
    mf3_pkg::t_chan r_mid_med [mf3_pkg::NUM_CH];
    mf3_pkg::t_chan r_hi_min  [mf3_pkg::NUM_CH];
    mf3_pkg::t_side r_side2;
    mf3_pkg::t_pix  r_ctr2;

    logic           r_valid;
    mf3_pkg::t_out  r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else if (i_en) begin
            for (int ch = 0; ch < mf3_pkg::NUM_CH; ch++) begin
                for (int row = 0; row < 3; row++) begin
                    r_rows[ch][row] <= mf3_pkg::sort3(
                        mf3_pkg::chan(i_win[3*row], ch),
                        mf3_pkg::chan(i_win[3*row + 1], ch),
                        mf3_pkg::chan(i_win[3*row + 2], ch));
                end
                // median of nine = med3(max of lows, med of mids, min of highs)
                r_lo_max[ch]  <= mf3_pkg::max3(r_rows[ch][0].lo, r_rows[ch][1].lo,
                                               r_rows[ch][2].lo);
                r_mid_med[ch] <= mf3_pkg::med3(r_rows[ch][0].mid, r_rows[ch][1].mid,
                                               r_rows[ch][2].mid);
                r_hi_min[ch]  <= mf3_pkg::min3(r_rows[ch][0].hi, r_rows[ch][1].hi,
                                               r_rows[ch][2].hi);
                r_data.pix[ch*mf3_pkg::CH_W +: mf3_pkg::CH_W] <= r_side2.interior ?
                    mf3_pkg::med3(r_lo_max[ch], r_mid_med[ch], r_hi_min[ch]) :
                    mf3_pkg::chan(r_ctr2, ch);
            end
            r_side1          <= i_side;
            r_ctr1           <= i_win[mf3_pkg::CENTER];
            r_side2          <= r_side1;
            r_ctr2           <= r_ctr1;
            r_valid          <= r_side2.valid;
            r_data.line_end  <= r_side2.line_end;
            r_data.frame_end <= r_side2.frame_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/core/mf3_skid.sv
// ----------------------------------------------------------------------------
// mf3_skid
// Output register with skid stage; upstream ready comes from a flop.
// ----------------------------------------------------------------------------
module mf3_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mf3_pkg::t_out i_data,
    output logic          o_ready,
    output logic          o_valid,
    output mf3_pkg::t_out o_data,
    input  logic          i_ready
);

    logic          r_out_valid;
    mf3_pkg::t_out r_out;
    logic          r_skid_valid;
    mf3_pkg::t_out r_skid;

    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_ready) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= i_data;
                    r_out_valid <= i_valid;
                end
            end else if (i_valid && !r_skid_valid) begin
                // output blocked: park the incoming word
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> rtl/core/median_filter_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_core
// Streaming 3x3 median filter on RGB pixels with one-pixel border pass-through.
// A result passes the front register, the window stages, the three median stages
// and the output register once the word that completes its window (position + width + 1) is accepted.
// Throughput: one word per cycle; the pipeline advances as one, held only by
// the output skid stage.
// Reset: synchronous; clears positions and pipeline, width 640, height 480.
// The line store is not cleared, so words are taken right after reset.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  mf3_pkg::t_reg_idx           i_cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]   i_cfg_data,
    // pixel input
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [mf3_pkg::PIX_W-1:0]   i_s_tdata,  // red_in, green_in, blue_in
    input  logic                        i_s_tuser,  // op
    // pixel output
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [mf3_pkg::PIX_W-1:0]   o_m_tdata,  // red_out, green_out, blue_out
    output logic                        o_m_tlast,  // line_end
    output logic                        o_m_tuser   // frame_end
);

    logic [mf3_pkg::CFG_W-1:0] r_width;
    logic [mf3_pkg::CFG_W-1:0] r_height;
    logic [mf3_pkg::COL_W-1:0] r_in_col,  n_in_col;
    logic [mf3_pkg::ROW_W-1:0] r_in_row,  n_in_row;
    logic [mf3_pkg::COL_W-1:0] r_out_col, n_out_col;
    logic [mf3_pkg::CFG_W-1:0] r_out_row, n_out_row;
    mf3_pkg::t_front           r_s0;

    logic [mf3_pkg::CFG_W-1:0] w_w;
    logic [mf3_pkg::CFG_W-1:0] w_h;
    logic [mf3_pkg::CFG_W-1:0] w_w_m1;
    logic [mf3_pkg::CFG_W-1:0] w_h_m1;
    logic                      w_en;
    logic                      w_cfg_wr;
    logic                      w_clear;
    logic                      w_draining;
    logic                      w_item;
    logic                      w_emit;
    logic                      w_in_last_col;
    logic                      w_out_last_col;
    logic                      w_out_last_row;
    logic                      w_interior;
    logic                      w_frame_end;

    mf3_pkg::t_win             w_win;
    mf3_pkg::t_side            w_side;
    logic                      w_med_valid;
    mf3_pkg::t_out             w_med_data;
    mf3_pkg::t_out             w_out;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_comb begin
        w_w = r_width;
        if (r_width == '0) begin
            w_w = mf3_pkg::CFG_W'(1);
        end else if (int'(r_width) > mf3_pkg::MAX_WIDTH) begin
            w_w = mf3_pkg::CFG_W'(mf3_pkg::MAX_WIDTH);
        end
        w_h    = (r_height == '0) ? mf3_pkg::CFG_W'(1) : r_height;
        w_w_m1 = w_w - 1'b1;
        w_h_m1 = w_h - 1'b1;
    end

    // frame position bookkeeping
    assign w_draining     = r_in_row >= mf3_pkg::ROW_W'(w_h);
    assign w_item         = i_s_tvalid & w_en & (w_draining | (i_s_tuser == mf3_pkg::OP_PIXEL));
    assign w_emit         = (r_in_row >= mf3_pkg::ROW_W'(2)) ||
                            ((r_in_row == mf3_pkg::ROW_W'(1)) && (r_in_col != '0));
    assign w_in_last_col  = mf3_pkg::CNT_W'(r_in_col) == mf3_pkg::CNT_W'(w_w_m1);
    assign w_out_last_col = mf3_pkg::CNT_W'(r_out_col) == mf3_pkg::CNT_W'(w_w_m1);
    assign w_out_last_row = r_out_row == w_h_m1;
    assign w_frame_end    = w_emit & w_out_last_col & w_out_last_row;
    assign w_interior     = (r_out_row != '0) && (r_out_row < w_h_m1) &&
                            (r_out_col != '0) &&
                            (mf3_pkg::CNT_W'(r_out_col) < mf3_pkg::CNT_W'(w_w_m1));
    assign w_clear        = w_cfg_wr &&
                            (i_cfg_index == mf3_pkg::REG_WIDTH ||
                             i_cfg_index == mf3_pkg::REG_HEIGHT);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_clear || (w_item && w_frame_end)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (w_item) begin
            if (w_in_last_col) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (w_emit) begin
                if (w_out_last_col) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= mf3_pkg::WIDTH_RESET;
            r_height   <= mf3_pkg::HEIGHT_RESET;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s0.valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    mf3_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                    mf3_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (w_en) begin
                r_s0.valid     <= w_item;
                r_s0.col       <= r_in_col;
                // drain ticks shift in black
                r_s0.px        <= w_draining ? '0 : i_s_tdata;
                r_s0.emit      <= w_emit;
                r_s0.interior  <= w_interior;
                r_s0.line_end  <= w_out_last_col;
                r_s0.frame_end <= w_frame_end;
            end
        end
    end

    assign o_s_tready = w_en;

    mf3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_front (r_s0),
        .o_win   (w_win),
        .o_side  (w_side)
    );

    mf3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_win   (w_win),
        .i_side  (w_side),
        .o_valid (w_med_valid),
        .o_data  (w_med_data)
    );

    mf3_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_med_valid),
        .i_data  (w_med_data),
        .o_ready (w_en),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = w_out.pix;
    assign o_m_tlast = w_out.line_end;
    assign o_m_tuser = w_out.frame_end;

endmodule
